[rtl/lfcl_pkg.sv]
// Package: constants, types and helpers for the leader-follower control law.
`timescale 1ns / 1ps
package lfcl_pkg;

  localparam int unsigned AngleBits   = 16;
  localparam int unsigned CordicSteps = 20;
  localparam int unsigned PosW        = 24;
  localparam int unsigned SpdW        = 16;
  localparam int unsigned CfgW        = 16;
  localparam int unsigned OutW        = 24;
  localparam int unsigned CfgIdxW     = 1;
  localparam int unsigned DivSteps    = 32;

  localparam logic signed [33:0] CordicK = 34'sd652032874;
  localparam logic signed [63:0] OutMax  = 64'sd8388607;
  localparam logic signed [63:0] OutMin  = -64'sd8388608;

  typedef enum logic [CfgIdxW-1:0] {
    REG_OFFSET_DIST = 1'b0,
    REG_POS_GAIN    = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic signed [PosW-1:0] lead_x;
    logic signed [PosW-1:0] lead_y;
    logic [AngleBits-1:0]   lead_heading;
    logic signed [SpdW-1:0] lead_speed;
    logic signed [PosW-1:0] follow_x;
    logic signed [PosW-1:0] follow_y;
    logic [AngleBits-1:0]   follow_heading;
  } pose_t;

  typedef struct packed {
    logic signed [OutW-1:0] drive_speed;
    logic signed [OutW-1:0] turn_rate;
    logic                   saturated;
  } cmd_t;

  typedef struct packed {
    logic signed [17:0] c;
    logic signed [17:0] s;
  } trig_t;

  typedef struct packed {
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [33:0] z;
    logic [1:0]         q;
  } cordic_t;

  function automatic logic signed [33:0] atan_turn(input int unsigned i);
    logic signed [33:0] r;
    begin
      case (i)
        0: r = 34'sh20000000;  1: r = 34'sh12E4051E;  2: r = 34'sh09FB385B;
        3: r = 34'sh051111D4;  4: r = 34'sh028B0D43;  5: r = 34'sh0145D7E1;
        6: r = 34'sh00A2F61E;  7: r = 34'sh00517C55;  8: r = 34'sh0028BE53;
        9: r = 34'sh00145F2F;  10: r = 34'sh000A2F98; 11: r = 34'sh000517CC;
        12: r = 34'sh00028BE6; 13: r = 34'sh000145F3; 14: r = 34'sh0000A2FA;
        15: r = 34'sh0000517D; 16: r = 34'sh000028BE; 17: r = 34'sh0000145F;
        18: r = 34'sh00000A30; default: r = 34'sh00000518;
      endcase
      return r;
    end
  endfunction

  function automatic cordic_t cordic_init(input logic [AngleBits-1:0] h);
    logic [31:0] a;
    logic [31:0] ru;
    logic [1:0]  q;
    cordic_t     r;
    begin
      a = {h, {(32-AngleBits){1'b0}}};
      q = 2'((a + 32'h2000_0000) >> 30);
      ru = a - {q, 30'd0};
      r.x = CordicK;
      r.y = '0;
      r.z = 34'(signed'(ru));
      r.q = q;
      return r;
    end
  endfunction

  function automatic cordic_t cordic_iter(input cordic_t v, input int unsigned i);
    cordic_t r;
    begin
      r = v;
      if (!v.z[33]) begin
        r.x = v.x - (v.y >>> i);
        r.y = v.y + (v.x >>> i);
        r.z = v.z - atan_turn(i);
      end else begin
        r.x = v.x + (v.y >>> i);
        r.y = v.y - (v.x >>> i);
        r.z = v.z + atan_turn(i);
      end
      return r;
    end
  endfunction

  function automatic trig_t cordic_final(input cordic_t v);
    logic signed [33:0] cc;
    logic signed [33:0] ss;
    trig_t r;
    begin
      cc = (v.x + 34'sd8192) >>> 14;
      ss = (v.y + 34'sd8192) >>> 14;
      case (v.q)
        2'd0: begin r.c = 18'(cc);  r.s = 18'(ss);  end
        2'd1: begin r.c = 18'(-ss); r.s = 18'(cc);  end
        2'd2: begin r.c = 18'(-cc); r.s = 18'(-ss); end
        default: begin r.c = 18'(ss); r.s = 18'(-cc); end
      endcase
      return r;
    end
  endfunction

endpackage

[rtl/lfcl_if.sv]
// Interface: valid/ready channel carrying one payload beat.
`timescale 1ns / 1ps
interface lfcl_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[rtl/lfcl_cordic.sv]
// Pipelined CORDIC: sine and cosine in Q16 of two binary angles.
`timescale 1ns / 1ps
module lfcl_cordic (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  logic [lfcl_pkg::AngleBits-1:0]    angle_a_i,
  input  logic [lfcl_pkg::AngleBits-1:0]    angle_b_i,
  output lfcl_pkg::trig_t                   trig_a_o,
  output lfcl_pkg::trig_t                   trig_b_o
);
  import lfcl_pkg::*;

  cordic_t a_q [CordicSteps+1];
  cordic_t b_q [CordicSteps+1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_q[0] <= cordic_init(angle_a_i);
      b_q[0] <= cordic_init(angle_b_i);
      for (int unsigned i = 0; i < CordicSteps; i++) begin
        a_q[i+1] <= cordic_iter(a_q[i], i);
        b_q[i+1] <= cordic_iter(b_q[i], i);
      end
    end
  end

  assign trig_a_o = cordic_final(a_q[CordicSteps]);
  assign trig_b_o = cordic_final(b_q[CordicSteps]);

endmodule

[rtl/lfcl_divider.sv]
// Pipelined restoring divider with sign restore and saturation.
`timescale 1ns / 1ps
module lfcl_divider (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic [39:0]          mag_i,
  input  logic [23:0]          den_i,
  input  logic                 neg_i,
  input  logic                 sat_i,
  input  logic signed [23:0]   drive_i,
  output lfcl_pkg::cmd_t       cmd_o
);
  import lfcl_pkg::*;

  typedef struct packed {
    logic [32:0]        rem;
    logic [31:0]        quo;
    logic [31:0]        num;
    logic [23:0]        den;
    logic               neg;
    logic               sat;
    logic signed [23:0] drive;
  } div_t;

  div_t st_q [DivSteps+1];
  div_t st_d [DivSteps];

  always_comb begin
    for (int unsigned i = 0; i < DivSteps; i++) begin
      logic [32:0] t;
      st_d[i] = st_q[i];
      t = {st_q[i].rem[31:0], st_q[i].num[31]};
      st_d[i].num = {st_q[i].num[30:0], 1'b0};
      if (t >= {9'd0, st_q[i].den}) begin
        st_d[i].rem = t - {9'd0, st_q[i].den};
        st_d[i].quo = {st_q[i].quo[30:0], 1'b1};
      end else begin
        st_d[i].rem = t;
        st_d[i].quo = {st_q[i].quo[30:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q[0].rem   <= {25'd0, mag_i[39:32]};
      st_q[0].quo   <= '0;
      st_q[0].num   <= mag_i[31:0];
      st_q[0].den   <= den_i;
      st_q[0].neg   <= neg_i;
      st_q[0].sat   <= sat_i;
      st_q[0].drive <= drive_i;
      for (int unsigned i = 0; i < DivSteps; i++) begin
        st_q[i+1] <= st_d[i];
      end
    end
  end

  logic signed [33:0] w;
  logic               wsat;
  always_comb begin
    w = st_q[DivSteps].neg ? -$signed({2'b0, st_q[DivSteps].quo})
                           :  $signed({2'b0, st_q[DivSteps].quo});
    wsat = 1'b0;
    cmd_o.turn_rate = w[23:0];
    if (w > 34'sd8388607) begin
      wsat = 1'b1; cmd_o.turn_rate = 24'sh7FFFFF;
    end else if (w < -34'sd8388608) begin
      wsat = 1'b1; cmd_o.turn_rate = -24'sh800000;
    end
    cmd_o.drive_speed = st_q[DivSteps].drive;
    cmd_o.saturated   = st_q[DivSteps].sat | wsat;
  end

endmodule

[rtl/leader_follower_control_law.sv]
// Top level: leader-follower offset-point control law, deep pipeline.
//
//  channel  | dir | payload          | handshake
//  pose_if  | in  | lfcl_pkg::pose_t | valid/ready
//  cmd_if   | out | lfcl_pkg::cmd_t  | valid/ready
//
// One beat enters every cycle while the output is not stalled; the pipe has 21 CORDIC
// stages, 6 arithmetic stages and 33 divider stages plus the output register.
// The whole pipe advances together; a stall at the output holds every stage.
// Reset clears valid bits and sets the registers to offset 1000, gain 1.0.
`timescale 1ns / 1ps
module leader_follower_control_law (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  lfcl_if.sink                          pose_if,
  lfcl_if.source                        cmd_if,
  input  logic                          cfg_we_i,
  input  logic [lfcl_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [lfcl_pkg::CfgW-1:0]     cfg_data_i
);
  import lfcl_pkg::*;

  localparam int unsigned CordLat = CordicSteps + 1;
  localparam int unsigned ArLat   = 6;
  localparam int unsigned DivLat  = DivSteps + 1;
  localparam int unsigned Depth   = CordLat + ArLat + DivLat;

  logic [CfgW-1:0] offset_q, gain_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= 16'd1000;
      gain_q   <= 16'd256;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_OFFSET_DIST: offset_q <= cfg_data_i;
        REG_POS_GAIN:    gain_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic [Depth-1:0] vld_q;
  logic             adv;
  logic             out_vld_q;
  cmd_t             out_q;

  assign adv = !out_vld_q || cmd_if.ready;
  assign pose_if.ready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      vld_q     <= {vld_q[Depth-2:0], pose_if.valid};
      out_vld_q <= vld_q[Depth-1];
    end
  end

  pose_t pose_q [CordLat];
  always_ff @(posedge clk_i) begin
    if (adv) begin
      pose_q[0] <= pose_if.data;
      for (int unsigned i = 1; i < CordLat; i++) pose_q[i] <= pose_q[i-1];
    end
  end

  trig_t tl, tf;
  lfcl_cordic u_cordic (
    .clk_i, .en_i(adv),
    .angle_a_i(pose_if.data.lead_heading),
    .angle_b_i(pose_if.data.follow_heading),
    .trig_a_o(tl), .trig_b_o(tf)
  );

  pose_t              p;
  logic [16:0]        d;
  assign p = pose_q[CordLat-1];
  assign d = (offset_q == '0) ? 17'd1 : {1'b0, offset_q};

  // stage A: products with trig, position differences
  logic signed [40:0] dcf_q, dsf_q, vcl_q, vsl_q;
  logic signed [24:0] dx_q, dy_q;
  trig_t              tf_a;
  // stage B: errors
  logic signed [48:0] ex_q, ey_q;
  logic signed [40:0] vcl_b, vsl_b;
  trig_t              tf_b;
  // stage C: u
  logic signed [49:0] u1_q, u2_q;
  trig_t              tf_c;
  // stage D: products u*trig
  logic signed [67:0] p1_q, p2_q, p3_q, p4_q;
  // stage E: fwd, lat
  logic signed [68:0] fwd_q, lat_q;
  // stage F: drive, num
  logic signed [23:0] drv_q;
  logic               dsat_q;
  logic [39:0]        mag_q;
  logic               neg_q;
  logic [23:0]        den_q;

  logic signed [68:0] drv_full, lat_r;
  logic signed [63:0] num;
  logic [63:0]        mag_full, n2_full, lim_full;
  always_comb begin
    drv_full = (fwd_q + (69'sd1 <<< 23)) >>> 24;
    lat_r    = (lat_q + (69'sd1 <<< 15)) >>> 16;
    num      = 64'(lat_r) * 64'sd1000;
    mag_full = num[63] ? 64'(-num) : 64'(num);
    n2_full  = (mag_full + {41'd0, d[15:0], 7'd0}) >> 8;
    lim_full = {25'd0, d[15:0], 23'd0} + {48'd0, d[15:0]};
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dcf_q <= 41'($signed({1'b0, d})) * 41'(tf.c);
      dsf_q <= 41'($signed({1'b0, d})) * 41'(tf.s);
      vcl_q <= 41'(p.lead_speed) * 41'(tl.c);
      vsl_q <= 41'(p.lead_speed) * 41'(tl.s);
      dx_q  <= 25'(p.lead_x) - 25'(p.follow_x);
      dy_q  <= 25'(p.lead_y) - 25'(p.follow_y);
      tf_a  <= tf;

      ex_q  <= (49'(dx_q) <<< 16) - 49'(dcf_q);
      ey_q  <= (49'(dy_q) <<< 16) - 49'(dsf_q);
      vcl_b <= vcl_q;
      vsl_b <= vsl_q;
      tf_b  <= tf_a;

      u1_q  <= 50'(((67'(vcl_b) <<< 8) + 67'(ex_q) * $signed({1'b0, gain_q})
               + 67'sd32768) >>> 16);
      u2_q  <= 50'(((67'(vsl_b) <<< 8) + 67'(ey_q) * $signed({1'b0, gain_q})
               + 67'sd32768) >>> 16);
      tf_c  <= tf_b;

      p1_q  <= 68'(u1_q) * 68'(tf_c.c);
      p2_q  <= 68'(u2_q) * 68'(tf_c.s);
      p3_q  <= 68'(u1_q) * 68'(tf_c.s);
      p4_q  <= 68'(u2_q) * 68'(tf_c.c);

      fwd_q <= 69'(p1_q) + 69'(p2_q);
      lat_q <= 69'(p4_q) - 69'(p3_q);

      dsat_q <= (drv_full > 69'(OutMax)) || (drv_full < 69'(OutMin));
      drv_q  <= (drv_full > 69'(OutMax)) ? 24'sh7FFFFF :
                (drv_full < 69'(OutMin)) ? -24'sh800000 : drv_full[23:0];
      neg_q  <= num[63];
      if (n2_full >= lim_full) begin
        mag_q <= 40'd16777216;
        den_q <= 24'd1;
      end else begin
        mag_q <= n2_full[39:0];
        den_q <= {8'd0, d[15:0]};
      end
    end
  end

  cmd_t div_cmd;
  lfcl_divider u_div (
    .clk_i, .en_i(adv),
    .mag_i(mag_q), .den_i(den_q), .neg_i(neg_q),
    .sat_i(dsat_q), .drive_i(drv_q), .cmd_o(div_cmd)
  );

  always_ff @(posedge clk_i) begin
    if (adv) out_q <= div_cmd;
  end

  assign cmd_if.valid = out_vld_q;
  assign cmd_if.data  = out_q;

`ifndef SYNTHESIS
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_if.valid && !cmd_if.ready |=> cmd_if.valid && $stable(cmd_if.data))
    else $error("output beat changed under stall");
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_if.valid |-> pose_if.ready)
    else $error("input stalled with empty output");
  a_valid_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$isunknown(cmd_if.valid))
    else $error("output valid unknown");
`endif

endmodule

[tb/leader_follower_control_law_test.sv]
// Testbench: leader-follower control law checked against a built-in predictor.
`timescale 1ns / 1ps
module leader_follower_control_law_test;
  import lfcl_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [CfgW-1:0] cfg_data_i = '0;

  lfcl_if #(.T(pose_t)) pose_if ();
  lfcl_if #(.T(cmd_t))  cmd_if ();

  leader_follower_control_law dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .pose_if(pose_if), .cmd_if(cmd_if),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_data_i(cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  localparam longint LatencyCycles = 70;

  longint offset_mm;
  longint gain_q8;
  cmd_t   cmd_queue[$];
  int     errors = 0;
  int     send_idle_pct = 0;
  int     recv_idle_pct = 0;
  bit     hold_off = 1'b0;

  function automatic longint shr_floor(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint rnd_shift(longint v, int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic longint turn_step(int i);
    longint steps[20] = '{
      64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
      64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
      64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
      64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518};
    return steps[i];
  endfunction

  task automatic heading_trig(input logic [AngleBits-1:0] h,
                              output longint co, output longint si);
    logic [31:0] a;
    logic [31:0] ru;
    logic [1:0] q;
    longint x, y, z, nx, cc, ss;
    a = {h, {(32 - AngleBits){1'b0}}};
    q = 2'((a + 32'h2000_0000) >> 30);
    ru = a - {q, 30'd0};
    z = longint'(signed'(ru));
    x = 652032874;
    y = 0;
    for (int i = 0; i < 20; i++) begin
      if (z >= 0) begin
        nx = x - shr_floor(y, i);
        y = y + shr_floor(x, i);
        z -= turn_step(i);
      end else begin
        nx = x + shr_floor(y, i);
        y = y - shr_floor(x, i);
        z += turn_step(i);
      end
      x = nx;
    end
    cc = rnd_shift(x, 14);
    ss = rnd_shift(y, 14);
    case (q)
      2'd0: begin co = cc;  si = ss;  end
      2'd1: begin co = -ss; si = cc;  end
      2'd2: begin co = -cc; si = -ss; end
      default: begin co = ss; si = -cc; end
    endcase
  endtask

  function automatic longint clamp24(longint v, ref bit sat);
    if (v > 8388607) begin
      sat = 1'b1;
      return 8388607;
    end
    if (v < -8388608) begin
      sat = 1'b1;
      return -8388608;
    end
    return v;
  endfunction

  task automatic predict_cmd(input pose_t p, output cmd_t c);
    longint cl, sl, cf, sf, d, ex, ey, u1, u2, fwd, lat, num, den, mag, w, drv;
    bit sat;
    sat = 1'b0;
    d = (offset_mm == 0) ? 1 : offset_mm;
    heading_trig(p.lead_heading, cl, sl);
    heading_trig(p.follow_heading, cf, sf);
    ex = longint'(p.lead_x) * 65536 - (longint'(p.follow_x) * 65536 + d * cf);
    ey = longint'(p.lead_y) * 65536 - (longint'(p.follow_y) * 65536 + d * sf);
    u1 = rnd_shift(longint'(p.lead_speed) * cl * 256 + gain_q8 * ex, 16);
    u2 = rnd_shift(longint'(p.lead_speed) * sl * 256 + gain_q8 * ey, 16);
    fwd = u1 * cf + u2 * sf;
    lat = -u1 * sf + u2 * cf;
    drv = clamp24(rnd_shift(fwd, 24), sat);
    num = rnd_shift(lat, 16) * 1000;
    den = d * 256;
    mag = (num < 0) ? -num : num;
    w = (mag + den / 2) / den;
    if (num < 0) w = -w;
    w = clamp24(w, sat);
    c.drive_speed = drv[23:0];
    c.turn_rate = w[23:0];
    c.saturated = sat;
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CfgW-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    if (idx == REG_OFFSET_DIST) offset_mm = val;
    else gain_q8 = val;
  endtask

  task automatic drain_cmds();
    while (cmd_queue.size() != 0) @(posedge clk_i);
    repeat (LatencyCycles) @(posedge clk_i);
  endtask

  task automatic send_pose(input pose_t p, input bit has_fixed, input cmd_t fixed);
    cmd_t c;
    while ($urandom_range(99) < send_idle_pct) begin
      pose_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    pose_if.valid <= 1'b1;
    pose_if.data <= p;
    do @(posedge clk_i); while (!pose_if.ready);
    if (has_fixed) c = fixed;
    else predict_cmd(p, c);
    cmd_queue.push_back(c);
  endtask

  function automatic pose_t random_pose();
    pose_t p;
    p = pose_t'({$urandom, $urandom, $urandom, $urandom, 16'($urandom)});
    case ($urandom_range(3))
      0: begin
        p.lead_x = $signed(24'($urandom_range(8000))) - 24'sd4000;
        p.lead_y = $signed(24'($urandom_range(8000))) - 24'sd4000;
        p.follow_x = p.lead_x - 24'($urandom_range(2000));
        p.follow_y = p.lead_y + 24'($urandom_range(2000)) - 24'sd1000;
      end
      default: ;
    endcase
    return p;
  endfunction

  typedef struct {
    pose_t p;
    bit    has_fixed;
    cmd_t  fixed;
  } pose_row_t;

  always @(posedge clk_i or negedge rst_ni) begin
    cmd_t exp_c;
    if (!rst_ni) begin
      cmd_if.ready <= 1'b0;
    end else begin
      if (cmd_if.valid && cmd_if.ready) begin
        if (cmd_queue.size() == 0) begin
          $display("%0t: unexpected beat %p", $time, cmd_if.data);
          errors++;
        end else begin
          exp_c = cmd_queue.pop_front();
          if (cmd_if.data.drive_speed !== exp_c.drive_speed ||
              cmd_if.data.turn_rate !== exp_c.turn_rate ||
              cmd_if.data.saturated !== exp_c.saturated) begin
            $display("%0t: mismatch expected %0d %0d %0b actual %0d %0d %0b", $time,
                     exp_c.drive_speed, exp_c.turn_rate, exp_c.saturated,
                     cmd_if.data.drive_speed, cmd_if.data.turn_rate,
                     cmd_if.data.saturated);
            errors++;
          end
        end
      end
      cmd_if.ready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    #50ms;
    $display("leader_follower_control_law test failed");
    $finish;
  end

  initial begin
    pose_row_t rows[$];
    pose_row_t r;
    cmd_t zero_cmd;
    pose_t p;
    logic [CfgW-1:0] offsets[4] = '{16'd1, 16'd65535, 16'd0, 16'd250};
    logic [CfgW-1:0] gains[4] = '{16'd0, 16'd65535, 16'd512, 16'd256};
    pose_if.valid = 1'b0;
    pose_if.data = '0;
    offset_mm = 1000;
    gain_q8 = 256;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    zero_cmd = '0;
    zero_cmd.drive_speed = -24'sd1000;
    r.p = '0; r.has_fixed = 1'b1; r.fixed = zero_cmd; rows.push_back(r);
    r.has_fixed = 1'b0;
    foreach (offsets[i]) begin
      r.p = '0; r.p.follow_heading = 16'(i * 16384); rows.push_back(r);
    end
    r.p = '0; r.p.lead_x = 24'sh7FFFFF; r.p.follow_x = 24'sh800000; rows.push_back(r);
    r.p = '0; r.p.lead_y = 24'sh800000; r.p.follow_y = 24'sh7FFFFF;
    r.p.follow_heading = 16'hFFFF; rows.push_back(r);
    r.p = '0; r.p.lead_speed = 16'sh7FFF; r.p.lead_heading = 16'h2000; rows.push_back(r);
    r.p = '0; r.p.lead_speed = 16'sh8000; r.p.lead_heading = 16'hE000;
    r.p.follow_heading = 16'h6000; rows.push_back(r);
    r.p = '1; rows.push_back(r);
    for (int i = 0; i < 8; i++) begin
      r.p = random_pose(); rows.push_back(r);
    end
    foreach (rows[i]) send_pose(rows[i].p, rows[i].has_fixed, rows[i].fixed);
    pose_if.valid <= 1'b0;
    drain_cmds();

    for (int phase = 0; phase < 4; phase++) begin
      write_reg(REG_OFFSET_DIST, offsets[phase]);
      write_reg(REG_POS_GAIN, gains[phase]);
      cfg_we_i <= 1'b0;
      send_idle_pct = (phase == 0) ? 20 : (phase == 1) ? 55 : 0;
      recv_idle_pct = (phase == 0) ? 55 : (phase == 1) ? 20 : 0;
      if (phase == 3) begin
        fork
          begin
            hold_off = 1'b1;
            repeat (200) @(posedge clk_i);
            hold_off = 1'b0;
          end
        join_none
      end
      for (int n = 0; n < 125; n++) begin
        p = random_pose();
        send_pose(p, 1'b0, zero_cmd);
        if (n == 60) begin
          pose_if.valid <= 1'b0;
          while (cmd_queue.size() != 0) @(posedge clk_i);
        end
      end
      pose_if.valid <= 1'b0;
      drain_cmds();
    end

    if (errors == 0 && cmd_queue.size() == 0) begin
      $display("leader_follower_control_law test passed");
    end else begin
      $display("leader_follower_control_law test failed");
    end
    $finish;
  end
endmodule
